>>> rtl/core/ote_pkg.sv
package ote_pkg;

  localparam int TABLE_DEPTH_DEF = 64;

  localparam int OP_W    = 3;
  localparam int ID_W    = 31;
  localparam int PRICE_W = 32;
  localparam int QTY_W   = 31;
  localparam int ST_W    = 2;
  localparam int CNT_OUT_W = 7;

  localparam logic [OP_W-1:0] OP_ADD       = 3'd0;
  localparam logic [OP_W-1:0] OP_MODIFY    = 3'd1;
  localparam logic [OP_W-1:0] OP_CANCEL    = 3'd2;
  localparam logic [OP_W-1:0] OP_EXEC_FULL = 3'd3;
  localparam logic [OP_W-1:0] OP_EXEC_PART = 3'd4;

  localparam logic [ST_W-1:0] ST_DONE      = 2'd0;
  localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [ST_W-1:0] ST_SHORT     = 2'd2;
  localparam logic [ST_W-1:0] ST_FULL      = 2'd3;

  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic               side;
    logic [PRICE_W-1:0] price;
    logic [QTY_W-1:0]   quantity;
  } entry_t;

  typedef struct packed {
    logic   match;
    entry_t ent;
  } cell_state_t;

  typedef struct packed {
    logic               cmp;
    logic [ID_W-1:0]    key;
    entry_t             add_ent;
    logic [PRICE_W-1:0] mod_price;
    logic [QTY_W-1:0]   mod_qty;
    logic [QTY_W-1:0]   sub_qty;
  } cell_bcast_t;

  typedef struct packed {
    logic occ;
    logic load;
    logic mod;
    logic subw;
    logic shift;
  } cell_sel_t;

endpackage

>>> rtl/core/ote_if.sv
interface ote_in_if;
  logic                       valid;
  logic                       ready;
  logic [ote_pkg::OP_W-1:0]    opcode;
  logic [ote_pkg::ID_W-1:0]    order_id;
  logic                       side;
  logic [ote_pkg::PRICE_W-1:0] price;
  logic [ote_pkg::QTY_W-1:0]   quantity;
  logic [ote_pkg::QTY_W-1:0]   exec_quantity;

  modport source (output valid, opcode, order_id, side, price, quantity, exec_quantity,
                  input ready);
  modport sink (input valid, opcode, order_id, side, price, quantity, exec_quantity,
                output ready);
endinterface

interface ote_out_if;
  logic                         valid;
  logic                         ready;
  logic [ote_pkg::ST_W-1:0]      status;
  logic [ote_pkg::CNT_OUT_W-1:0] removed_count;
  logic [ote_pkg::QTY_W-1:0]     remaining_quantity;
  logic [ote_pkg::CNT_OUT_W-1:0] entry_count;

  modport source (output valid, status, removed_count, remaining_quantity, entry_count,
                  input ready);
  modport sink (input valid, status, removed_count, remaining_quantity, entry_count,
                output ready);
endinterface

>>> rtl/core/order_table_engine_unit.sv
// channel | dir | handshake   | payload
// req     | in  | valid/ready | opcode, order_id, side, price, quantity, exec_quantity
// rsp     | out | valid/ready | status, removed_count, remaining_quantity, entry_count
//
// Add, modify, execute fully: EVAL. Execute partially: EVAL, then PART.
// Cancel: EVAL per removed entry; cells close one gap per cycle unless rsp stalls.
// req is taken only between operations; rsp holds one result in an output register.
// A stalled rsp holds the finishing step; the table stays unchanged until it drains.
// Synchronous reset empties the table at once.
module order_table_engine_unit #(
  parameter int TABLE_DEPTH = ote_pkg::TABLE_DEPTH_DEF
) (
  input logic clk,
  input logic rst,
  ote_in_if.sink    req,
  ote_out_if.source rsp
);
  import ote_pkg::*;

  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EVAL = 2'd1;
  localparam logic [1:0] S_PART = 2'd2;

  logic [1:0]         state, state_next;
  logic [CNT_W-1:0]   count, count_next;
  logic [CNT_W-1:0]   rem, rem_next;
  logic [QTY_W-1:0]   qsel, qsel_next;

  logic [OP_W-1:0]    op;
  logic [ID_W-1:0]    id_r;
  logic               side_r;
  logic [PRICE_W-1:0] price_r;
  logic [QTY_W-1:0]   qty_r;
  logic [QTY_W-1:0]   xq_r;

  logic               out_valid;
  logic [ST_W-1:0]    out_status;
  logic [CNT_W-1:0]   out_removed;
  logic [QTY_W-1:0]   out_remaining;
  logic [CNT_W-1:0]   out_count;

  cell_state_t        cell_o [TABLE_DEPTH+1];
  cell_sel_t          sel    [TABLE_DEPTH];
  cell_bcast_t        bcast;

  logic [TABLE_DEPTH-1:0] m, mm1, low, ge, occ_v, dec_v;
  logic [TABLE_DEPTH-1:0] load_v, mod_v, subw_v, shift_v;
  logic               any, full, go, accept, fin, do_remove;
  logic [ST_W-1:0]    st;
  logic [QTY_W-1:0]   remain, diff, qsel_or;

  assign accept    = req.valid && req.ready;
  assign req.ready = (state == S_IDLE);
  assign go        = !out_valid || rsp.ready;
  assign full      = (count == CNT_W'(TABLE_DEPTH));

  genvar gi;
  generate
    for (gi = 0; gi < TABLE_DEPTH; gi++) begin : g_cell
      assign m[gi]     = cell_o[gi].match;
      assign occ_v[gi] = (CNT_W'(gi) < count);
      assign dec_v[gi] = (CNT_W'(gi) == count);
      assign sel[gi].occ   = occ_v[gi];
      assign sel[gi].load  = load_v[gi];
      assign sel[gi].mod   = mod_v[gi];
      assign sel[gi].subw  = subw_v[gi];
      assign sel[gi].shift = shift_v[gi];
      ote_cell u_cell (
        .clk   (clk),
        .rst   (rst),
        .bcast (bcast),
        .sel   (sel[gi]),
        .nbr   (cell_o[gi+1]),
        .cur   (cell_o[gi])
      );
    end
  endgenerate

  assign cell_o[TABLE_DEPTH] = '0;

  assign mm1 = m - TABLE_DEPTH'(1);
  assign low = m & ~mm1;
  assign ge  = ~(~m & mm1);
  assign any = |m;
  assign diff = qsel - xq_r;

  always_comb begin
    qsel_or = '0;
    for (int k = 0; k < TABLE_DEPTH; k++) begin
      qsel_or = qsel_or | (cell_o[k].ent.quantity & {QTY_W{low[k]}});
    end
  end

  always_comb begin
    bcast.cmp              = accept;
    bcast.key              = req.order_id;
    bcast.add_ent.id       = id_r;
    bcast.add_ent.side     = side_r;
    bcast.add_ent.price    = price_r;
    bcast.add_ent.quantity = qty_r;
    bcast.mod_price        = price_r;
    bcast.mod_qty          = qty_r;
    bcast.sub_qty          = diff;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      id_r <= req.order_id;
    end
  end

  always_comb begin
    state_next = state;
    count_next = count;
    rem_next   = rem;
    qsel_next  = qsel;
    fin        = 1'b0;
    st         = ST_DONE;
    remain     = '0;
    do_remove  = 1'b0;
    load_v     = '0;
    mod_v      = '0;
    subw_v     = '0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_EVAL;
          rem_next   = '0;
        end
      end
      S_EVAL: begin
        if (go) begin
          unique case (op)
            OP_ADD: begin
              fin = 1'b1;
              if (full) begin
                st = ST_FULL;
              end else begin
                load_v     = dec_v;
                count_next = count + CNT_W'(1);
              end
            end
            OP_MODIFY: begin
              fin = 1'b1;
              if (any) begin
                mod_v = low;
              end else begin
                st = ST_NOT_FOUND;
              end
            end
            OP_CANCEL: begin
              if (any) begin
                do_remove  = 1'b1;
                count_next = count - CNT_W'(1);
                rem_next   = rem + CNT_W'(1);
              end else begin
                fin = 1'b1;
              end
            end
            OP_EXEC_FULL: begin
              fin = 1'b1;
              if (any) begin
                do_remove  = 1'b1;
                count_next = count - CNT_W'(1);
                rem_next   = rem + CNT_W'(1);
              end else begin
                st = ST_NOT_FOUND;
              end
            end
            OP_EXEC_PART: begin
              if (any) begin
                qsel_next  = qsel_or;
                state_next = S_PART;
              end else begin
                fin = 1'b1;
                st  = ST_NOT_FOUND;
              end
            end
            default: begin
              fin = 1'b1;
            end
          endcase
        end
      end
      S_PART: begin
        if (go) begin
          fin = 1'b1;
          priority if (xq_r > qsel) begin
            st = ST_SHORT;
          end else if (xq_r < qsel) begin
            subw_v = low;
            remain = diff;
          end else begin
            do_remove  = 1'b1;
            count_next = count - CNT_W'(1);
            rem_next   = rem + CNT_W'(1);
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    if (fin) begin
      state_next = S_IDLE;
    end
  end

  assign shift_v = ge & {TABLE_DEPTH{do_remove}};

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rem       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      rem   <= rem_next;
      if (fin) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    qsel <= qsel_next;
    if (accept) begin
      op      <= req.opcode;
      side_r  <= req.side;
      price_r <= req.price;
      qty_r   <= req.quantity;
      xq_r    <= req.exec_quantity;
    end
    if (fin) begin
      out_status    <= st;
      out_removed   <= rem_next;
      out_remaining <= remain;
      out_count     <= count_next;
    end
  end

  logic [CNT_W+CNT_OUT_W-1:0] rem_ext, cnt_ext;
  assign rem_ext = {{CNT_OUT_W{1'b0}}, out_removed};
  assign cnt_ext = {{CNT_OUT_W{1'b0}}, out_count};

  assign rsp.valid              = out_valid;
  assign rsp.status             = out_status;
  assign rsp.removed_count      = rem_ext[CNT_OUT_W-1:0];
  assign rsp.remaining_quantity = out_remaining;
  assign rsp.entry_count        = cnt_ext[CNT_OUT_W-1:0];

endmodule

>>> rtl/core/ote_cell.sv
module ote_cell (
  input  logic                 clk,
  input  logic                 rst,
  input  ote_pkg::cell_bcast_t bcast,
  input  ote_pkg::cell_sel_t   sel,
  input  ote_pkg::cell_state_t nbr,
  output ote_pkg::cell_state_t cur
);
  import ote_pkg::*;

  entry_t ent;
  logic   match;

  always_ff @(posedge clk) begin
    if (sel.shift) begin
      ent <= nbr.ent;
    end else if (sel.load) begin
      ent <= bcast.add_ent;
    end else if (sel.mod) begin
      ent.price    <= bcast.mod_price;
      ent.quantity <= bcast.mod_qty;
    end else if (sel.subw) begin
      ent.quantity <= bcast.sub_qty;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      match <= 1'b0;
    end else if (sel.shift) begin
      match <= nbr.match;
    end else if (bcast.cmp) begin
      match <= sel.occ && (ent.id == bcast.key);
    end
  end

  assign cur.match = match;
  assign cur.ent   = ent;

endmodule
